/* sv/csd_pkg.sv */
// Shared types, codes and helpers for the chunk stream deframer.
package csd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned TS_W     = 24;
    localparam int unsigned LEN_W    = 24;
    localparam int unsigned TYPE_W   = 8;
    localparam int unsigned STREAM_W = 32;
    localparam int unsigned CHAN_W   = 6;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned CSIZE_W  = 24;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned CIDX_W   = 1;

    // Packed width of the result tdata, rounded up to whole bytes
    localparam int unsigned RES_BITS = BYTE_W + TS_W + LEN_W + TYPE_W + STREAM_W
                                     + CHAN_W + 1 + COUNT_W;
    localparam int unsigned RES_W    = ((RES_BITS + 7) / 8) * 8;

    // Byte kinds
    localparam logic [KIND_W-1:0] BK_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] BK_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] BK_CONT    = 2'd2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_CHUNK_SIZE = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_ACK_WINDOW = 1'b1;

    // Control message types
    localparam logic [TYPE_W-1:0] MSG_SET_CHUNK = 8'd1;
    localparam logic [TYPE_W-1:0] MSG_WINDOW    = 8'd5;

    // Chunk header types and their full header sizes
    localparam logic [1:0] CT_FULL  = 2'd0;
    localparam logic [1:0] CT_DELTA = 2'd1;
    localparam logic [1:0] CT_TIME  = 2'd2;
    localparam logic [3:0] HLEN_FULL  = 4'd12;
    localparam logic [3:0] HLEN_DELTA = 4'd8;
    localparam logic [3:0] HLEN_TIME  = 4'd4;
    localparam logic [3:0] HLEN_CONT  = 4'd1;

    localparam logic [CSIZE_W-1:0] CSIZE_MAX   = '1;
    localparam logic [CSIZE_W-1:0] RST_CSIZE   = 24'd128;
    localparam logic [COUNT_W-1:0] RST_WINDOW  = 32'd2500000;

    typedef struct packed {
        logic [KIND_W-1:0]   byte_kind;
        logic                message_done;
        logic [COUNT_W-1:0]  ack_value;
        logic                ack_now;
        logic [CHAN_W-1:0]   chunk_channel;
        logic [STREAM_W-1:0] msg_stream;
        logic [TYPE_W-1:0]   msg_kind;
        logic [LEN_W-1:0]    msg_length;
        logic [TS_W-1:0]     msg_timestamp;
        logic [BYTE_W-1:0]   payload_byte;
    } res_item_t;

    typedef struct packed {
        logic               valid;
        logic [CIDX_W-1:0]  index;
        logic [CFG_W-1:0]   data;
    } cfg_write_t;

    function automatic logic [CSIZE_W-1:0] clamp_chunk(input logic [CFG_W-1:0] v);
        logic [CSIZE_W-1:0] r;
        if (v == '0)
            r = {{(CSIZE_W-1){1'b0}}, 1'b1};
        else if (v[CFG_W-1:CSIZE_W] != '0)
            r = CSIZE_MAX;
        else
            r = v[CSIZE_W-1:0];
        return r;
    endfunction

endpackage

/* sv/csd_in_reg.sv */
// Input register stage: holds one received byte until the parser takes it.
module csd_in_reg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [csd_pkg::BYTE_W-1:0]    s_tdata,
    input  logic                          take,
    output logic                          byte_valid,
    output logic [csd_pkg::BYTE_W-1:0]    byte_data
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [csd_pkg::BYTE_W-1:0] data_reg;
    logic                       load;

    assign s_tready   = !valid_reg || take;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

/* sv/csd_parse.sv */
// Header parser, payload counters, acknowledge accounting and result register.
module csd_parse
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_valid,
    input  logic [csd_pkg::BYTE_W-1:0]    byte_data,
    output logic                          take,
    input  csd_pkg::cfg_write_t           cfg,
    output logic                          res_valid,
    input  logic                          res_ready,
    output csd_pkg::res_item_t            res
);

    localparam logic [1:0] PH_BASIC   = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_CONT    = 2'd3;

    logic [1:0]                    phase_reg, phase_next;
    logic [3:0]                    pos_reg, pos_next;
    logic [3:0]                    hlen_reg, hlen_next;
    logic [1:0]                    ctype_reg, ctype_next;
    logic [csd_pkg::TS_W-1:0]      ts_reg, ts_next;
    logic [csd_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [csd_pkg::TYPE_W-1:0]    type_reg, type_next;
    logic [csd_pkg::STREAM_W-1:0]  stream_reg, stream_next;
    logic [csd_pkg::CHAN_W-1:0]    chan_reg, chan_next;
    logic [csd_pkg::LEN_W-1:0]     left_reg, left_next;
    logic [csd_pkg::CSIZE_W-1:0]   fill_reg, fill_next;
    logic [csd_pkg::CFG_W-1:0]     cw_reg, cw_next;
    logic [csd_pkg::CSIZE_W-1:0]   csize_reg, csize_next;
    logic [csd_pkg::COUNT_W-1:0]   win_reg, win_next;
    logic [csd_pkg::COUNT_W-1:0]   total_reg, total_next;
    logic [csd_pkg::COUNT_W-1:0]   acked_reg, acked_next;
    logic                          valid_reg, valid_next;
    csd_pkg::res_item_t            res_reg, res_next;

    logic                          begin_pl;
    logic                          finish;
    logic [3:0]                    hlen_dec;
    logic [3:0]                    hlen_cur;
    logic [csd_pkg::LEN_W-1:0]     consumed;
    logic [csd_pkg::COUNT_W-1:0]   sum;
    logic [csd_pkg::COUNT_W-1:0]   since_ack;

    assign take       = byte_valid && (!valid_reg || res_ready);
    assign valid_next = take ? 1'b1 : (res_ready ? 1'b0 : valid_reg);

    always_comb
    begin
        unique case (byte_data[7:6])
            csd_pkg::CT_FULL:  hlen_dec = csd_pkg::HLEN_FULL;
            csd_pkg::CT_DELTA: hlen_dec = csd_pkg::HLEN_DELTA;
            csd_pkg::CT_TIME:  hlen_dec = csd_pkg::HLEN_TIME;
            default:           hlen_dec = csd_pkg::HLEN_CONT;
        endcase
    end

    assign hlen_cur  = (phase_reg == PH_BASIC) ? hlen_dec : hlen_reg;
    assign consumed  = len_reg - left_reg;
    assign sum       = total_reg + {{(csd_pkg::COUNT_W-csd_pkg::LEN_W){1'b0}}, len_reg}
                     + {{(csd_pkg::COUNT_W-4){1'b0}}, hlen_cur};
    assign since_ack = sum - acked_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        hlen_next   = hlen_reg;
        ctype_next  = ctype_reg;
        ts_next     = ts_reg;
        len_next    = len_reg;
        type_next   = type_reg;
        stream_next = stream_reg;
        chan_next   = chan_reg;
        left_next   = left_reg;
        fill_next   = fill_reg;
        cw_next     = cw_reg;
        csize_next  = csize_reg;
        win_next    = win_reg;
        total_next  = total_reg;
        acked_next  = acked_reg;
        res_next    = res_reg;
        begin_pl    = 1'b0;
        finish      = 1'b0;

        if (take)
        begin
            res_next = '0;
            unique case (phase_reg)
                PH_BASIC:
                begin
                    ctype_next = byte_data[7:6];
                    chan_next  = byte_data[csd_pkg::CHAN_W-1:0];
                    hlen_next  = hlen_dec;
                    pos_next   = 4'd1;
                    if (hlen_dec > csd_pkg::HLEN_CONT)
                        phase_next = PH_HEADER;
                    else
                        begin_pl = 1'b1;
                end
                PH_HEADER:
                begin
                    if (ctype_reg == csd_pkg::CT_FULL)
                    begin
                        priority if (pos_reg <= 4'd3)
                            ts_next = {ts_reg[csd_pkg::TS_W-9:0], byte_data};
                        else if (pos_reg <= 4'd6)
                            len_next = {len_reg[csd_pkg::LEN_W-9:0], byte_data};
                        else if (pos_reg == 4'd7)
                            type_next = byte_data;
                        else if (pos_reg == 4'd8)
                            stream_next[7:0] = byte_data;
                        else if (pos_reg == 4'd9)
                            stream_next[15:8] = byte_data;
                        else if (pos_reg == 4'd10)
                            stream_next[23:16] = byte_data;
                        else if (pos_reg == 4'd11)
                            stream_next[31:24] = byte_data;
                    end
                    pos_next = pos_reg + 4'd1;
                    if (pos_next >= hlen_reg)
                        begin_pl = 1'b1;
                end
                PH_PAYLOAD:
                begin
                    res_next.byte_kind    = csd_pkg::BK_PAYLOAD;
                    res_next.payload_byte = byte_data;
                    if (consumed < 24'd4)
                        cw_next = {cw_reg[csd_pkg::CFG_W-9:0], byte_data};
                    left_next = left_reg - 24'd1;
                    fill_next = fill_reg + 24'd1;
                    if (left_next == '0)
                        finish = 1'b1;
                    else if (fill_next >= csize_reg)
                    begin
                        fill_next  = '0;
                        phase_next = PH_CONT;
                    end
                end
                default:
                begin
                    res_next.byte_kind = csd_pkg::BK_CONT;
                    phase_next         = PH_PAYLOAD;
                end
            endcase

            if (begin_pl)
            begin
                left_next = len_reg;
                fill_next = '0;
                cw_next   = '0;
                if (len_reg == '0)
                    finish = 1'b1;
                else
                    phase_next = PH_PAYLOAD;
            end

            if (finish)
            begin
                res_next.message_done = 1'b1;
                total_next = sum;
                if (since_ack >= win_reg)
                begin
                    res_next.ack_now   = 1'b1;
                    res_next.ack_value = sum;
                    acked_next         = sum;
                end
                if (len_reg >= 24'd4)
                begin
                    if (type_reg == csd_pkg::MSG_SET_CHUNK)
                        csize_next = csd_pkg::clamp_chunk(cw_next);
                    else if (type_reg == csd_pkg::MSG_WINDOW)
                        win_next = cw_next;
                end
                phase_next = PH_BASIC;
            end

            res_next.msg_timestamp = ts_next;
            res_next.msg_length    = len_next;
            res_next.msg_kind      = type_next;
            res_next.msg_stream    = stream_next;
            res_next.chunk_channel = chan_next;
        end

        if (cfg.valid)
        begin
            unique case (cfg.index)
                csd_pkg::CFG_CHUNK_SIZE:
                    csize_next = csd_pkg::clamp_chunk(
                        {{(csd_pkg::CFG_W-csd_pkg::CSIZE_W){1'b0}},
                         cfg.data[csd_pkg::CSIZE_W-1:0]});
                default:
                    win_next = cfg.data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_BASIC;
            pos_reg    <= '0;
            hlen_reg   <= csd_pkg::HLEN_CONT;
            ctype_reg  <= '0;
            ts_reg     <= '0;
            len_reg    <= '0;
            type_reg   <= '0;
            stream_reg <= '0;
            chan_reg   <= '0;
            left_reg   <= '0;
            fill_reg   <= '0;
            cw_reg     <= '0;
            csize_reg  <= csd_pkg::RST_CSIZE;
            win_reg    <= csd_pkg::RST_WINDOW;
            total_reg  <= '0;
            acked_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            hlen_reg   <= hlen_next;
            ctype_reg  <= ctype_next;
            ts_reg     <= ts_next;
            len_reg    <= len_next;
            type_reg   <= type_next;
            stream_reg <= stream_next;
            chan_reg   <= chan_next;
            left_reg   <= left_next;
            fill_reg   <= fill_next;
            cw_reg     <= cw_next;
            csize_reg  <= csize_next;
            win_reg    <= win_next;
            total_reg  <= total_next;
            acked_reg  <= acked_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

/* sv/chunk_stream_deframer.sv */
// Top level of the chunk stream deframer: input stage, parser and result port.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    s_tdata: byte_in
//  m_*       out  m_tvalid/m_tready    m_tdata: result fields, m_tuser: byte_kind,
//                                      m_tlast: message_done
//  cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One item per cycle sustained while m_tready is high; each goes through the input register, then the result register.
//  Each item is parsed in a single pass of counter and field logic between the two.
//  Reset clears the parser to expect a basic header, chunk size 128, window 2500000.
//  A stalled result holds while one more item waits in the input register.
//  Configuration writes are always taken.
module chunk_stream_deframer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [csd_pkg::BYTE_W-1:0]         s_tdata,  // [7:0] byte_in
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] payload_byte, [31:8] msg_timestamp, [55:32] msg_length,
    // [63:56] msg_kind, [95:64] msg_stream, [101:96] chunk_channel,
    // [102] ack_now, [134:103] ack_value, [135] zero
    output logic [csd_pkg::RES_W-1:0]          m_tdata,
    output logic [csd_pkg::KIND_W-1:0]         m_tuser,  // [1:0] byte_kind
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [csd_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [csd_pkg::CFG_W-1:0]          cfg_data
);

    logic                        byte_valid;
    logic [csd_pkg::BYTE_W-1:0]  byte_data;
    logic                        take;
    csd_pkg::cfg_write_t         cfg;
    csd_pkg::res_item_t          res;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    csd_in_reg u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    csd_parse u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .take       (take),
        .cfg        (cfg),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {{(csd_pkg::RES_W-csd_pkg::RES_BITS){1'b0}},
                      res.ack_value, res.ack_now, res.chunk_channel, res.msg_stream,
                      res.msg_kind, res.msg_length, res.msg_timestamp, res.payload_byte};
    assign m_tuser = res.byte_kind;
    assign m_tlast = res.message_done;

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != csd_pkg::BK_PAYLOAD) |-> m_tdata[7:0] == 8'd0)
        else $error("payload byte set on a non-payload item");

    a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[102] |-> m_tdata[134:103] == 32'd0)
        else $error("ack value without acknowledge");

    a_ack_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[102] |-> m_tlast)
        else $error("acknowledge outside message end");

    a_cont_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == csd_pkg::BK_CONT) |-> !m_tlast)
        else $error("continuation byte ended a message");

endmodule

/* tb/chunk_stream_deframer_tb.sv */
// Self-checking testbench for chunk_stream_deframer: message streams, control updates, acks.
module chunk_stream_deframer_tb;
    import csd_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CALM_FROM    = 1650;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [1:0] CT_NEXT = 2'd3;

    typedef enum logic [1:0]
    {
        EXPECT_BASIC,
        IN_HEADER,
        IN_PAYLOAD,
        SKIP_CONT
    } parse_state_e;

    class deframer_scoreboard;
        parse_state_e        pstate;
        logic [3:0]          hdr_pos;
        logic [3:0]          hdr_len;
        logic [1:0]          hdr_type;
        logic [TS_W-1:0]     ts;
        logic [LEN_W-1:0]    len;
        logic [TYPE_W-1:0]   mtype;
        logic [STREAM_W-1:0] stream;
        logic [CHAN_W-1:0]   chan;
        logic [LEN_W-1:0]    left;
        logic [LEN_W-1:0]    fill;
        logic [31:0]         ctrl;
        logic [CSIZE_W-1:0]  csize;
        logic [COUNT_W-1:0]  window;
        logic [COUNT_W-1:0]  total;
        logic [COUNT_W-1:0]  acked;
        res_item_t           byte_results_q[$];
        int                  errors;
        int                  n_results;
        int                  n_done;
        int                  n_acks;
        int                  n_cont;

        function new();
            pstate = EXPECT_BASIC;
            hdr_pos = 4'd0;
            hdr_len = HLEN_CONT;
            hdr_type = CT_FULL;
            ts = '0;
            len = '0;
            mtype = '0;
            stream = '0;
            chan = '0;
            left = '0;
            fill = '0;
            ctrl = '0;
            csize = RST_CSIZE;
            window = RST_WINDOW;
            total = '0;
            acked = '0;
            errors = 0;
            n_results = 0;
            n_done = 0;
            n_acks = 0;
            n_cont = 0;
        endfunction

        function logic [CSIZE_W-1:0] fit_chunk_size(input logic [31:0] v);
            if (v == 0)
                return 24'd1;
            if (v > 32'hFFFFFF)
                return CSIZE_MAX;
            return v[CSIZE_W-1:0];
        endfunction

        function int pending();
            return byte_results_q.size();
        endfunction

        function void apply_register(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
            if (idx == CFG_CHUNK_SIZE)
                csize = fit_chunk_size({8'h00, data[23:0]});
            else
                window = data;
        endfunction

        function void close_message(inout res_item_t r);
            r.message_done = 1'b1;
            n_done++;
            total = total + 32'(len) + 32'(hdr_len);
            if (total - acked >= window)
            begin
                r.ack_now = 1'b1;
                r.ack_value = total;
                acked = total;
                n_acks++;
            end
            if (len >= 4)
            begin
                if (mtype == MSG_SET_CHUNK)
                    csize = fit_chunk_size(ctrl);
                else if (mtype == MSG_WINDOW)
                    window = ctrl;
            end
            pstate = EXPECT_BASIC;
        endfunction

        function void start_payload(inout res_item_t r);
            left = len;
            fill = '0;
            ctrl = '0;
            if (len == 0)
                close_message(r);
            else
                pstate = IN_PAYLOAD;
        endfunction

        function void note_byte(input logic [BYTE_W-1:0] b);
            res_item_t r;
            int sh;
            r = '0;
            case (pstate)
                EXPECT_BASIC:
                begin
                    hdr_type = b[7:6];
                    chan = b[5:0];
                    case (hdr_type)
                        CT_FULL:  hdr_len = HLEN_FULL;
                        CT_DELTA: hdr_len = HLEN_DELTA;
                        CT_TIME:  hdr_len = HLEN_TIME;
                        default:  hdr_len = HLEN_CONT;
                    endcase
                    hdr_pos = 4'd1;
                    if (hdr_len > 1)
                        pstate = IN_HEADER;
                    else
                        start_payload(r);
                end
                IN_HEADER:
                begin
                    if (hdr_type == CT_FULL)
                    begin
                        if (hdr_pos <= 3)
                            ts = {ts[15:0], b};
                        else if (hdr_pos <= 6)
                            len = {len[15:0], b};
                        else if (hdr_pos == 7)
                            mtype = b;
                        else if (hdr_pos <= 11)
                        begin
                            sh = (int'(hdr_pos) - 8) * 8;
                            stream[sh +: 8] = b;
                        end
                    end
                    hdr_pos = hdr_pos + 4'd1;
                    if (hdr_pos >= hdr_len)
                        start_payload(r);
                end
                IN_PAYLOAD:
                begin
                    r.byte_kind = BK_PAYLOAD;
                    r.payload_byte = b;
                    if (len - left < 4)
                        ctrl = {ctrl[23:0], b};
                    left = left - 1'b1;
                    fill = fill + 1'b1;
                    if (left == 0)
                        close_message(r);
                    else if (fill >= csize)
                    begin
                        fill = '0;
                        pstate = SKIP_CONT;
                    end
                end
                default:
                begin
                    r.byte_kind = BK_CONT;
                    n_cont++;
                    pstate = IN_PAYLOAD;
                end
            endcase
            r.msg_timestamp = ts;
            r.msg_length = len;
            r.msg_kind = mtype;
            r.msg_stream = stream;
            r.chunk_channel = chan;
            byte_results_q.push_back(r);
        endfunction

        function void check_result(input logic [RES_W-1:0] td, input logic [KIND_W-1:0] tu,
                                   input logic tl);
            res_item_t e;
            bit bad;
            n_results++;
            if (byte_results_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result %0d with nothing expected: kind %0d data %h",
                             n_results, tu, td);
                return;
            end
            e = byte_results_q.pop_front();
            bad = (tu !== e.byte_kind) || (tl !== e.message_done)
                || (td[7:0] !== e.payload_byte) || (td[31:8] !== e.msg_timestamp)
                || (td[55:32] !== e.msg_length) || (td[63:56] !== e.msg_kind)
                || (td[95:64] !== e.msg_stream) || (td[101:96] !== e.chunk_channel)
                || (td[102] !== e.ack_now) || (td[134:103] !== e.ack_value)
                || (td[RES_W-1] !== 1'b0);
            if (bad)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("result %0d expected: kind %0d byte %h done %b ts %h len %h type %h",
                             n_results, e.byte_kind, e.payload_byte, e.message_done,
                             e.msg_timestamp, e.msg_length, e.msg_kind);
                    $display("    stream %h chan %h ack %b/%h; got kind %0d done %b data %h",
                             e.msg_stream, e.chunk_channel, e.ack_now, e.ack_value,
                             tu, tl, td);
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [RES_W-1:0]    m_tdata;
    logic [KIND_W-1:0]   m_tuser;
    logic                m_tlast;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    deframer_scoreboard  sb;
    int                  n_sent;
    int                  quiet;
    int                  rx_hold;
    bit                  tx_idle_on;
    bit                  rx_idle_on;
    int unsigned         gen_csize;
    int unsigned         gen_left;
    int unsigned         gen_fill;
    int                  gen_pos;
    logic [LEN_W-1:0]    gen_len;
    logic [TYPE_W-1:0]   gen_type;
    logic [31:0]         gen_plan;

    chunk_stream_deframer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int gap_left;
        gap_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                m_tready <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                gap_left = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (tx_idle_on && $urandom_range(0, 6) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_byte(b);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.apply_register(idx, data);
        if (idx == CFG_CHUNK_SIZE)
            gen_csize = 32'(sb.fit_chunk_size({8'h00, data[23:0]}));
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] pick_chunk_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 32'd0;
        if (r < 16)
            return 32'd1;
        if (r < 24)
            return 32'hFFFFFF;
        if (r < 32)
            return 32'hFFFFFFFF;
        if (r < 40)
            return {8'($urandom_range(1, 255)), 24'($urandom)};
        if (r < 70)
            return $urandom_range(2, 16);
        return $urandom_range(17, 200);
    endfunction

    function automatic logic [31:0] pick_window_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'd0;
        if (r < 20)
            return 32'hFFFFFFFF;
        if (r < 30)
            return RST_WINDOW;
        if (r < 60)
            return $urandom_range(1, 100);
        return $urandom_range(100, 1500);
    endfunction

    task automatic open_message(input logic [1:0] ct, input logic [CHAN_W-1:0] ch,
                                input logic [TS_W-1:0] ts, input logic [LEN_W-1:0] len,
                                input logic [TYPE_W-1:0] mt, input logic [STREAM_W-1:0] st,
                                input logic [31:0] plan);
        send_byte({ct, ch});
        case (ct)
            CT_FULL:
            begin
                send_byte(ts[23:16]);
                send_byte(ts[15:8]);
                send_byte(ts[7:0]);
                send_byte(len[23:16]);
                send_byte(len[15:8]);
                send_byte(len[7:0]);
                send_byte(mt);
                send_byte(st[7:0]);
                send_byte(st[15:8]);
                send_byte(st[23:16]);
                send_byte(st[31:24]);
                gen_len = len;
                gen_type = mt;
            end
            CT_DELTA:
                repeat (HLEN_DELTA - 1) send_byte(8'($urandom_range(0, 255)));
            CT_TIME:
                repeat (HLEN_TIME - 1) send_byte(8'($urandom_range(0, 255)));
            default:
                ;
        endcase
        gen_plan = plan;
        gen_left = 32'(gen_len);
        gen_fill = 0;
        gen_pos = 0;
    endtask

    task automatic send_payload(input int unsigned n);
        int unsigned k;
        logic [BYTE_W-1:0] b;
        for (k = 0; k < n && gen_left != 0; k++)
        begin
            if (gen_pos < 4)
                b = 8'(gen_plan >> (8 * (3 - gen_pos)));
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b);
            gen_pos++;
            gen_left--;
            gen_fill++;
            if (gen_left == 0)
            begin
                if (gen_len >= 4 && gen_type == MSG_SET_CHUNK)
                    gen_csize = 32'(sb.fit_chunk_size(gen_plan));
            end
            else if (gen_fill >= gen_csize)
            begin
                gen_fill = 0;
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic random_message(input bit keep_partial);
        int r;
        logic [1:0] ct;
        logic [LEN_W-1:0] len;
        logic [TYPE_W-1:0] mt;
        logic [TYPE_W-1:0] eff;
        logic [31:0] plan;
        r = $urandom_range(0, 99);
        ct = r < 70 ? CT_FULL : r < 80 ? CT_DELTA : r < 90 ? CT_TIME : CT_NEXT;
        r = $urandom_range(0, 99);
        if (r < 10)
            len = '0;
        else if (r < 20)
            len = 24'($urandom_range(1, 3));
        else if (r < 35)
            len = 24'd4;
        else if (r < 97)
            len = 24'($urandom_range(5, 48));
        else
            len = 24'($urandom_range(100, 260));
        r = $urandom_range(0, 99);
        mt = r < 20 ? MSG_SET_CHUNK : r < 35 ? MSG_WINDOW : 8'($urandom_range(0, 255));
        eff = ct == CT_FULL ? mt : gen_type;
        if (eff == MSG_SET_CHUNK)
            plan = pick_chunk_word();
        else if (eff == MSG_WINDOW)
            plan = pick_window_word();
        else
            plan = $urandom;
        open_message(ct, 6'($urandom_range(0, 63)), 24'($urandom), len, mt, $urandom, plan);
        if (keep_partial)
            send_payload($urandom_range(0, gen_left));
        else
            send_payload(gen_left);
    endtask

    initial
    begin
        int phase_no;
        int msgs;
        sb = new();
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CHUNK_SIZE;
        cfg_data = '0;
        rst_n = 1'b0;
        n_sent = 0;
        quiet = 0;
        rx_hold = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        gen_csize = 32'(RST_CSIZE);
        gen_left = 0;
        gen_fill = 0;
        gen_pos = 0;
        gen_len = '0;
        gen_type = '0;
        gen_plan = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        open_message(CT_FULL, 6'd0, 24'hFFFFFF, 24'd0, 8'hFF, 32'hFFFFFFFF, 32'd0);
        open_message(CT_NEXT, 6'h3F, 24'd0, 24'd0, 8'd0, 32'd0, 32'd0);
        open_message(CT_DELTA, 6'h2A, 24'd0, 24'd0, 8'd0, 32'd0, 32'd0);
        open_message(CT_TIME, 6'h15, 24'd0, 24'd0, 8'd0, 32'd0, 32'd0);

        phase_no = 0;
        while (n_sent < RANDOM_ITEMS)
        begin
            wait_results_drained();
            if (phase_no == 0)
            begin
                write_register(CFG_CHUNK_SIZE, 32'd0);
                write_register(CFG_ACK_WINDOW, 32'd0);
            end
            else if (phase_no == 1)
            begin
                write_register(CFG_CHUNK_SIZE, 32'hFFFFFFFF);
                write_register(CFG_ACK_WINDOW, 32'hFFFFFFFF);
            end
            else
            begin
                if ($urandom_range(0, 9) < 6)
                    write_register(CFG_CHUNK_SIZE, pick_chunk_word());
                if ($urandom_range(0, 9) < 6)
                    write_register(CFG_ACK_WINDOW, pick_window_word());
            end
            cfg_valid <= 1'b0;
            if (phase_no == 3)
                rx_hold = HOLD_CYCLES;
            if (n_sent >= CALM_FROM)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (gen_left != 0)
                send_payload(gen_left);
            msgs = $urandom_range(2, 5);
            for (int m = 0; m < msgs; m++)
                random_message(m == msgs - 1 && $urandom_range(0, 3) == 0);
            phase_no++;
        end
        if (gen_left != 0)
            send_payload(gen_left);
        open_message(CT_FULL, 6'($urandom_range(0, 63)), 24'($urandom), 24'hFFFFFF,
                     8'($urandom_range(0, 255)), $urandom, $urandom);
        send_payload(40);

        wait_results_drained();
        repeat (8) @(negedge clk);
        $display("sent %0d bytes over %0d settings; %0d results, %0d messages closed",
                 n_sent, phase_no, sb.n_results, sb.n_done);
        $display("%0d acknowledgements, %0d continuation bytes skipped, %0d mismatches",
                 sb.n_acks, sb.n_cont, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
